// File: hw/rtl/mbde_pkg.sv
// ----------------------------------------------------------------------------
// mbde_pkg
// Shared types and constants for the multi-button debounce event block.
// ----------------------------------------------------------------------------
package mbde_pkg;

    // number of buttons held in the block (1..8)
    localparam int BUTTONS = 8;
    localparam int BTN_W   = (BUTTONS > 1) ? $clog2(BUTTONS) : 1;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 64;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_TIME = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COMMAND_TABLE = 2'd1;

    localparam logic [15:0] DEBOUNCE_RESET = 16'd30;

    // item function codes
    localparam logic FUNC_INIT = 1'b0;
    localparam logic FUNC_POLL = 1'b1;

    typedef struct packed {
        logic        func;
        logic [2:0]  button_index;
        logic        pin_level;
        logic [31:0] time_ms;
    } t_in_word;

    typedef struct packed {
        logic        debounced;
        logic        press_event;
        logic [7:0]  command;
        logic [31:0] edge_count;
    } t_out_word;

    typedef struct packed {
        logic [15:0] debounce_time;
        logic [63:0] command_table;
    } t_cfg;

endpackage

// File: hw/rtl/mbde_cfg.sv
// ----------------------------------------------------------------------------
// mbde_cfg
// Configuration register file: debounce time and per-button command bytes.
// ----------------------------------------------------------------------------
module mbde_cfg (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [mbde_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [mbde_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output mbde_pkg::t_cfg                      o_cfg
);

    mbde_pkg::t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_time <= mbde_pkg::DEBOUNCE_RESET;
            r_cfg.command_table <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                mbde_pkg::CFG_DEBOUNCE_TIME: r_cfg.debounce_time <= i_cfg_data[15:0];
                mbde_pkg::CFG_COMMAND_TABLE: r_cfg.command_table <= i_cfg_data;
                default: ;  // unmapped index, write dropped
            endcase
        end
    end

endmodule

// File: hw/rtl/mbde_in_reg.sv
// ----------------------------------------------------------------------------
// mbde_in_reg
// Input register stage: holds one accepted word until the engine takes it.
// ----------------------------------------------------------------------------
module mbde_in_reg (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  mbde_pkg::t_in_word  i_word,
    output logic                o_valid,
    input  logic                i_take,
    output mbde_pkg::t_in_word  o_word
);

    logic               r_valid;
    mbde_pkg::t_in_word r_word;

    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_word  = r_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_word <= i_word;
        end
    end

endmodule

// File: hw/rtl/mbde_engine.sv
// ----------------------------------------------------------------------------
// mbde_engine
// Per-button debounce state and single-pass update of the addressed button.
// ----------------------------------------------------------------------------
module mbde_engine (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_fire,
    input  mbde_pkg::t_in_word  i_word,
    input  mbde_pkg::t_cfg      i_cfg,
    output mbde_pkg::t_out_word o_res
);

    localparam int B  = mbde_pkg::BUTTONS;
    localparam int BW = mbde_pkg::BTN_W;

    logic [B-1:0]  r_raw;
    logic [B-1:0]  r_stable;
    logic [B-1:0]  r_idle;
    logic [B-1:0]  r_sent;
    logic [31:0]   r_chg [B];
    logic [31:0]   r_total;

    logic [BW-1:0] b;
    logic          in_range;
    logic          cur_raw;
    logic          cur_stable;
    logic          cur_idle;
    logic          cur_sent;
    logic [31:0]   cur_chg;
    logic [31:0]   elapsed;
    logic          held;
    logic          active;

    logic          n_raw;
    logic          n_stable;
    logic          n_idle;
    logic          n_sent;
    logic [31:0]   n_chg;
    logic [31:0]   n_total;
    logic          press;
    logic [7:0]    cmd;

    assign b        = i_word.button_index[BW-1:0];
    assign in_range = {1'b0, i_word.button_index} < 4'(B);

    always_comb begin
        cur_raw    = r_raw[b];
        cur_stable = r_stable[b];
        cur_idle   = r_idle[b];
        cur_sent   = r_sent[b];
        cur_chg    = r_chg[b];
        elapsed    = i_word.time_ms - cur_chg;
        held       = elapsed >= {16'd0, i_cfg.debounce_time};
        active     = i_word.pin_level != cur_idle;

        n_raw    = cur_raw;
        n_stable = cur_stable;
        n_idle   = cur_idle;
        n_sent   = cur_sent;
        n_chg    = cur_chg;
        n_total  = r_total;
        press    = 1'b0;
        cmd      = '0;

        if (i_word.func == mbde_pkg::FUNC_INIT) begin
            n_idle   = i_word.pin_level;
            n_raw    = i_word.pin_level;
            n_stable = i_word.pin_level;
            n_chg    = i_word.time_ms;
            n_sent   = 1'b0;
        end else if (i_word.pin_level != cur_raw) begin
            // raw edge: restart the hold timer
            n_raw = i_word.pin_level;
            n_chg = i_word.time_ms;
        end else if (i_word.pin_level != cur_stable && held) begin
            n_stable = i_word.pin_level;
            if (active && !cur_sent) begin
                n_total = r_total + 32'd1;
                cmd     = i_cfg.command_table[{b, 3'b000} +: 8];
                press   = 1'b1;
                n_sent  = 1'b1;
            end else if (!active) begin
                n_sent = 1'b0;   // back at idle, re-arm
            end
        end

        if (in_range) begin
            o_res.debounced   = n_stable;
            o_res.press_event = press;
            o_res.command     = cmd;
            o_res.edge_count  = n_total;
        end else begin
            o_res.debounced   = 1'b0;
            o_res.press_event = 1'b0;
            o_res.command     = '0;
            o_res.edge_count  = r_total;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_raw    <= '0;
            r_stable <= '0;
            r_idle   <= '0;
            r_sent   <= '0;
            r_total  <= '0;
            for (int i = 0; i < B; i++) begin
                r_chg[i] <= '0;
            end
        end else if (i_fire && in_range) begin
            r_raw[b]    <= n_raw;
            r_stable[b] <= n_stable;
            r_idle[b]   <= n_idle;
            r_sent[b]   <= n_sent;
            r_chg[b]    <= n_chg;
            r_total     <= n_total;
        end
    end

endmodule

// File: hw/rtl/multi_button_debounce_event.sv
// ----------------------------------------------------------------------------
// multi_button_debounce_event
// Debouncer for up to eight buttons sharing one sample stream, with press
// events carrying a per-button command byte.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_item): one word per sample,
//   naming the button, its pin level and the millisecond time. An init word
//   captures the idle level; poll words run the debounce timer.
//   Output channel (o_out_valid / i_out_ready / o_out_item): exactly one word
//   per input word, in order: stable level, press flag, command byte and the
//   running press count.
//   Config channel (i_cfg_valid / o_cfg_ready / i_cfg_index / i_cfg_data):
//   index 0 debounce time in ms, index 1 command table. Always ready; write
//   only while no word is in flight.
//   Datapath: an accepted word waits in the input register, which feeds the
//   state update; its result is registered when the output register frees.
//   Throughput: one word per cycle when not stalled; the per-button state
//   update is one subtract and compare on the addressed button's registers.
//   Reset: synchronous, active low; all button state and the press count
//   clear, debounce time returns to 30 ms, command table to zero.
//   Stall: a held result keeps its register; the input register still takes
//   one more word, then o_in_ready drops until the output is taken.
// ----------------------------------------------------------------------------
module multi_button_debounce_event (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  mbde_pkg::t_in_word               i_in_item,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output mbde_pkg::t_out_word              o_out_item,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [mbde_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [mbde_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    mbde_pkg::t_cfg      cfg;
    mbde_pkg::t_in_word  stage_word;
    mbde_pkg::t_out_word res;
    logic                stage_valid;
    logic                advance;
    logic                fire;

    logic                r_out_valid;
    mbde_pkg::t_out_word r_out_item;

    // result register frees up when empty or being drained this cycle
    assign advance = !r_out_valid || i_out_ready;
    assign fire    = stage_valid && advance;

    mbde_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    mbde_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_word  (i_in_item),
        .o_valid (stage_valid),
        .i_take  (advance),
        .o_word  (stage_word)
    );

    // state is committed on the same edge the result is registered, so a
    // following word for the same button sees the updated state
    mbde_engine u_engine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_word  (stage_word),
        .i_cfg   (cfg),
        .o_res   (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= stage_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_item <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

// File: tb/mbde_scoreboard_pkg.sv
// ----------------------------------------------------------------------------
// mbde_scoreboard_pkg
// Press predictor and result scoreboard for the multi-button debouncer.
// ----------------------------------------------------------------------------
package mbde_scoreboard_pkg;

    import mbde_pkg::*;

    class press_scoreboard;

        // shadow of the block's registers
        bit [15:0]   hold_time;
        bit [63:0]   cmd_table;

        // per-button shadow state
        bit [7:0]    raw_lvl;
        bit [7:0]    stable_lvl;
        bit [7:0]    idle_lvl;
        bit [7:0]    sent_mark;
        bit [31:0]   change_ms [8];
        bit [31:0]   press_count;

        t_out_word   expected_words[$];
        int unsigned errors;

        function new();
            hold_time   = DEBOUNCE_RESET;
            cmd_table   = '0;
            raw_lvl     = '0;
            stable_lvl  = '0;
            idle_lvl    = '0;
            sent_mark   = '0;
            foreach (change_ms[k]) change_ms[k] = '0;
            press_count = '0;
            errors      = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_DEBOUNCE_TIME: hold_time = data[15:0];
                CFG_COMMAND_TABLE: cmd_table = data;
                default: ;
            endcase
        endfunction

        // Runs one accepted word through the debounce rules, queues its result.
        function void predict_press(t_in_word w);
            t_out_word   r;
            int unsigned b;
            bit [31:0]   held_ms;
            r = '0;
            b = w.button_index;
            if (b < BUTTONS) begin
                held_ms = w.time_ms - change_ms[b];
                if (w.func == FUNC_INIT) begin
                    idle_lvl[b]   = w.pin_level;
                    raw_lvl[b]    = w.pin_level;
                    stable_lvl[b] = w.pin_level;
                    change_ms[b]  = w.time_ms;
                    sent_mark[b]  = 1'b0;
                end else if (w.pin_level != raw_lvl[b]) begin
                    raw_lvl[b]   = w.pin_level;
                    change_ms[b] = w.time_ms;
                end else if (w.pin_level != stable_lvl[b] && held_ms >= hold_time) begin
                    stable_lvl[b] = w.pin_level;
                    if (w.pin_level != idle_lvl[b] && !sent_mark[b]) begin
                        press_count   = press_count + 1;
                        r.press_event = 1'b1;
                        r.command     = cmd_table[8*b +: 8];
                        sent_mark[b]  = 1'b1;
                    end else if (w.pin_level == idle_lvl[b]) begin
                        sent_mark[b] = 1'b0;
                    end
                end
                r.debounced = stable_lvl[b];
            end
            r.edge_count = press_count;
            expected_words.push_back(r);
        endfunction

        function void check_result(t_out_word got);
            t_out_word exp_w;
            if (expected_words.size() == 0) begin
                $error("result word with nothing expected: %h", got);
                errors++;
                return;
            end
            exp_w = expected_words.pop_front();
            if (got.debounced !== exp_w.debounced) begin
                $error("debounced: expected %0d, got %0d", exp_w.debounced,
                       got.debounced);
                errors++;
            end
            if (got.press_event !== exp_w.press_event) begin
                $error("press_event: expected %0d, got %0d", exp_w.press_event,
                       got.press_event);
                errors++;
            end
            if (got.command !== exp_w.command) begin
                $error("command: expected %h, got %h", exp_w.command, got.command);
                errors++;
            end
            if (got.edge_count !== exp_w.edge_count) begin
                $error("edge_count: expected %0d, got %0d", exp_w.edge_count,
                       got.edge_count);
                errors++;
            end
        endfunction

        function int pending();
            return expected_words.size();
        endfunction

    endclass

endpackage

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for multi_button_debounce_event. A directed burst walks
// through press, release, bounce, re-init and timer wrap; then several config
// phases (zero, one, maximum and random debounce times, varied command tables)
// run streams of realistic button activity mixed with noise. Every result
// word is checked against a shadow model in the scoreboard class.
// ----------------------------------------------------------------------------
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import mbde_pkg::*;
    import mbde_scoreboard_pkg::*;

    localparam int ITEMS_PER_PHASE = 180;
    localparam int PHASES          = 8;
    localparam int STALL_LIMIT     = 4000;  // cycles with no handshake at all

    // ------------------------------------------------------------------------
    // clock, reset, DUT ports
    // ------------------------------------------------------------------------
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                  in_valid  = 1'b0;
    t_in_word              in_item   = '0;
    logic                  out_ready = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_DEBOUNCE_TIME;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    logic      o_in_ready;
    logic      o_out_valid;
    t_out_word o_out_item;
    logic      o_cfg_ready;

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    multi_button_debounce_event i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (o_out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    press_scoreboard score = new();

    // stimulus-side view of the world
    bit          steady = 1'b0;     // when set, neither side idles
    logic [31:0] ms_now = '0;       // free-running millisecond time
    bit [7:0]    pin_now = '0;      // physical level of each button
    int unsigned stall_cycles = 0;

    // ------------------------------------------------------------------------
    // Monitor: one process sees every handshake at the edge, so the order of
    // predict and check never hinges on scheduling. Also drives the random
    // back-pressure and the no-progress watchdog.
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        if (rst_n) begin
            if (cfg_valid && o_cfg_ready)
                score.write_reg(cfg_index, cfg_data);
            if (in_valid && o_in_ready)
                score.predict_press(in_item);
            if (o_out_valid && out_ready)
                score.check_result(o_out_item);

            if ((cfg_valid && o_cfg_ready) || (in_valid && o_in_ready) ||
                (o_out_valid && out_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("status: fail");
                $finish;
            end
        end
        // ~31% of cycles stalled, none while the steady stretch runs
        out_ready <= steady || ($urandom_range(0, 99) >= 31);
    end

    // ------------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------------

    // Offers one word; returns at the edge where it was taken.
    task automatic send_word(input t_in_word w);
        while (!steady && $urandom_range(0, 99) < 31) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= w;
        do @(posedge clk); while (!o_in_ready);
    endtask

    task automatic send_fields(input logic func, input int unsigned b,
                               input logic lvl, input logic [31:0] t);
        t_in_word w;
        w.func         = func;
        w.button_index = 3'(b);
        w.pin_level    = lvl;
        w.time_ms      = t;
        send_word(w);
    endtask

    // Drops valid and waits until every queued result has come back.
    task automatic wait_drained();
        in_valid <= 1'b0;
        do @(posedge clk); while (score.pending() != 0);
    endtask

    // Both registers back to back; the upper bits of the debounce write are
    // junk the block must ignore.
    task automatic write_config(input logic [15:0] dt, input logic [63:0] cmd_bytes);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_DEBOUNCE_TIME;
        cfg_data  <= {$urandom, 16'($urandom), dt};
        do @(posedge clk); while (!o_cfg_ready);
        cfg_index <= CFG_COMMAND_TABLE;
        cfg_data  <= cmd_bytes;
        do @(posedge clk); while (!o_cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // One word of simulated button activity. Time moves forward in steps
    // scaled to the debounce time so levels actually settle; buttons get
    // pressed and released, sometimes re-initialized, and a slice of words
    // carry bounce, arbitrary time stamps or long silences.
    task automatic random_word(input logic [15:0] dt);
        t_in_word    w;
        int unsigned roll;
        int unsigned b;
        roll   = $urandom_range(0, 99);
        b      = $urandom_range(0, BUTTONS - 1);
        ms_now = ms_now + $urandom_range(0, dt / 3 + 2);
        if (roll >= 94 && roll < 96)
            ms_now = ms_now + $urandom;
        w.button_index = 3'(b);
        if (roll < 6) begin
            w.func     = FUNC_INIT;
            pin_now[b] = 1'($urandom_range(0, 1));
            w.pin_level = pin_now[b];
        end else begin
            w.func = FUNC_POLL;
            if (roll < 20)
                pin_now[b] = ~pin_now[b];
            // contact bounce: a random level instead of the physical one
            w.pin_level = (roll >= 88) ? 1'($urandom_range(0, 1)) : pin_now[b];
        end
        w.time_ms = (roll >= 97) ? $urandom : ms_now;
        send_word(w);
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin
        logic [15:0] dt;
        logic [63:0] cmd_bytes;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Directed burst on reset config (30 ms, all commands zero).
        // Button 0 polled before any init: idle level 0.
        send_fields(FUNC_POLL, 0, 1'b1, 32'd5);
        send_fields(FUNC_POLL, 0, 1'b1, 32'd34);    // 29 ms, not yet
        send_fields(FUNC_POLL, 0, 1'b1, 32'd35);    // exactly 30 ms: press
        send_fields(FUNC_POLL, 0, 1'b1, 32'd100);   // held, no second press
        send_fields(FUNC_POLL, 0, 1'b0, 32'd101);   // bounce down...
        send_fields(FUNC_POLL, 0, 1'b1, 32'd102);   // ...and back up
        send_fields(FUNC_POLL, 0, 1'b1, 32'd200);
        send_fields(FUNC_POLL, 0, 1'b0, 32'd300);   // release
        send_fields(FUNC_POLL, 0, 1'b0, 32'd330);   // back to idle, re-armed
        send_fields(FUNC_POLL, 0, 1'b1, 32'd331);
        send_fields(FUNC_POLL, 0, 1'b1, 32'd400);   // second press
        // Active-low button, debounce window straddles the time wrap.
        send_fields(FUNC_INIT, 1, 1'b1, 32'hFFFF_FFF0);
        send_fields(FUNC_POLL, 1, 1'b0, 32'hFFFF_FFFA);
        send_fields(FUNC_POLL, 1, 1'b0, 32'h0000_0018);
        send_fields(FUNC_INIT, 1, 1'b0, 32'h0000_0000);  // re-init mid-press
        send_fields(FUNC_INIT, 7, 1'b1, 32'hFFFF_FFFF);
        send_fields(FUNC_POLL, 7, 1'b0, 32'h0000_0000);
        send_fields(FUNC_POLL, 7, 1'b0, 32'd29);
        send_fields(FUNC_POLL, 7, 1'b0, 32'd30);
        for (int b = 2; b < 7; b++)
            send_fields(FUNC_INIT, b, 1'(b), (b % 2) ? 32'h5555_5555 : 32'hAAAA_AAAA);
        wait_drained();

        // Random phases, each with its own register settings.
        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: begin
                    dt        = 16'd0;             // stable on first repeat
                    cmd_bytes = '1;
                end
                1: begin
                    dt        = 16'hFFFF;
                    cmd_bytes = 64'h8040_2010_0804_0201;
                end
                2: begin
                    dt        = 16'd1;
                    cmd_bytes = '0;
                end
                default: begin
                    dt        = 16'($urandom_range(2, 60));
                    cmd_bytes = {$urandom, $urandom};
                end
            endcase
            if (p == 3)
                ms_now = 32'hFFFF_FC00;            // cross the wrap in this phase
            write_config(dt, cmd_bytes);
            steady = (p == 4);
            for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
                random_word(dt);
                if (p == 2 && i == ITEMS_PER_PHASE / 2)
                    wait_drained();                // sender holds off until empty
            end
            wait_drained();
        end
        steady = 1'b0;

        // tail: catch any stray words after the last expected one
        repeat (8) @(posedge clk);
        if (score.pending() != 0) begin
            $error("%0d expected result words never arrived", score.pending());
            score.errors++;
        end
        if (score.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
